// ===== hw/rtl/limit_switch_homing_axis_controller_macros.svh =====
// Assertion macros shared by the homing axis controller RTL.
`ifndef LIMIT_SWITCH_HOMING_AXIS_CONTROLLER_MACROS_SVH
`define LIMIT_SWITCH_HOMING_AXIS_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define LSH_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsh: same-cycle check failed");
// next-cycle implication
`define LSH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsh: next-cycle check failed");
`else
`define LSH_ASSERT_SAME(lbl, ante, cons)
`define LSH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/lsh_pkg.sv =====
// Types and constants of the homing axis controller.
`default_nettype none
package lsh_pkg;

  // configuration register widths and reset values
  localparam int SEEK_W     = 15;
  localparam int SETTLE_W   = 16;
  localparam int HALF_W     = 31;
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [SEEK_W-1:0]   SEEK_RESET   = 15'd6554;  // 0.2 in Q0.15
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd500;
  localparam logic [HALF_W-1:0]   HALF_MAX     = 31'h7FFF_FFFF;

  // register indexes (byte address / 4)
  localparam logic [CFG_IDX_W-1:0] REG_SEEK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 1'b1;

  // homing sequencer phase
  typedef enum logic [2:0] {
    PH_RUN    = 3'd0,
    PH_LEFT   = 3'd1,
    PH_RIGHT  = 3'd2,
    PH_CENTER = 3'd3,
    PH_SETTLE = 3'd4
  } lsh_phase_t;

  typedef struct packed {
    logic [SEEK_W-1:0]   seek_speed;
    logic [SETTLE_W-1:0] settle_ticks;
  } lsh_cfg_t;

  // single-bit status of one result beat
  typedef struct packed {
    logic driver_disable;
    logic zero_position;
    logic reset_done;
    logic enabled;
    logic homing_busy;
  } lsh_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lsh_in_if.sv =====
// Input tick channel: limit switches, position, speed command, homing request.
`default_nettype none
interface lsh_in_if #(
  parameter int POSITION_BITS = 32,
  parameter int SPEED_BITS    = 16
);
  logic                     valid;
  logic                     ready;
  logic                     limit_left;
  logic                     limit_right;
  logic [POSITION_BITS-1:0] position;
  logic [SPEED_BITS-1:0]    speed_command;
  logic                     reset_request;

  modport source (
    output valid, limit_left, limit_right, position, speed_command, reset_request,
    input  ready
  );
  modport sink (
    input  valid, limit_left, limit_right, position, speed_command, reset_request,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/lsh_out_if.sv =====
// Result channel: speed, driver and homing status, reported position.
`default_nettype none
interface lsh_out_if #(
  parameter int POSITION_BITS = 32,
  parameter int SPEED_BITS    = 16
);
  logic                          valid;
  logic                          ready;
  logic [SPEED_BITS-1:0]         speed_out;
  logic                          driver_disable;
  logic                          zero_position;
  logic                          reset_done;
  logic                          enabled;
  logic                          homing_busy;
  logic [POSITION_BITS-1:0]      reported_position;
  logic [lsh_pkg::HALF_W-1:0]    half_travel;

  modport source (
    output valid, speed_out, driver_disable, zero_position, reset_done, enabled,
           homing_busy, reported_position, half_travel,
    input  ready
  );
  modport sink (
    input  valid, speed_out, driver_disable, zero_position, reset_done, enabled,
           homing_busy, reported_position, half_travel,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/lsh_cfg_regs.sv =====
// APB-style configuration registers: seek speed and settle time.
`default_nettype none
module lsh_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lsh_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [lsh_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [lsh_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready,
  output lsh_pkg::lsh_cfg_t                       cfg
);

  logic [lsh_pkg::SEEK_W-1:0]    seek_r;
  logic [lsh_pkg::SETTLE_W-1:0]  settle_r;
  logic [lsh_pkg::CFG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lsh_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seek_r   <= lsh_pkg::SEEK_RESET;
      settle_r <= lsh_pkg::SETTLE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        lsh_pkg::REG_SEEK:   seek_r   <= pwdata[lsh_pkg::SEEK_W-1:0];
        lsh_pkg::REG_SETTLE: settle_r <= pwdata[lsh_pkg::SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (reg_idx)
      lsh_pkg::REG_SEEK:   prdata = lsh_pkg::APB_DATA_W'(seek_r);
      lsh_pkg::REG_SETTLE: prdata = lsh_pkg::APB_DATA_W'(settle_r);
      default:             prdata = '0;
    endcase
  end

  assign cfg.seek_speed   = seek_r;
  assign cfg.settle_ticks = settle_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lsh_core.sv =====
// Homing sequencer and run-mode datapath; state moves on each stepped beat.
`default_nettype none
`include "limit_switch_homing_axis_controller_macros.svh"
module lsh_core #(
  parameter int POSITION_BITS = 32,
  parameter int SPEED_BITS    = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            step,
  input  wire lsh_pkg::lsh_cfg_t               cfg,
  input  wire logic                            limit_left,
  input  wire logic                            limit_right,
  input  wire logic [POSITION_BITS-1:0]        position,
  input  wire logic [SPEED_BITS-1:0]           speed_command,
  input  wire logic                            reset_request,
  output logic      [SPEED_BITS-1:0]           speed_out,
  output lsh_pkg::lsh_flags_t                  flags,
  output logic      [POSITION_BITS-1:0]        reported_position,
  output logic      [lsh_pkg::HALF_W-1:0]      half_travel
);

  localparam int SW    = (SPEED_BITS > lsh_pkg::SEEK_W + 1) ? SPEED_BITS
                                                            : lsh_pkg::SEEK_W + 1;
  localparam int HWIDE = (POSITION_BITS - 1 > lsh_pkg::HALF_W) ? POSITION_BITS - 1
                                                              : lsh_pkg::HALF_W;

  lsh_pkg::lsh_phase_t               phase_r, phase_nxt;
  logic [POSITION_BITS-1:0]          left_cap_r, left_cap_nxt;
  logic [POSITION_BITS-1:0]          center_r, center_nxt;
  logic [lsh_pkg::HALF_W-1:0]        half_r, half_nxt;
  logic [lsh_pkg::HALF_W-1:0]        half_pend_r, half_pend_nxt;
  logic [lsh_pkg::SETTLE_W-1:0]      settle_cnt_r, settle_cnt_nxt;
  logic                              enable_r, enable_nxt;
  logic [POSITION_BITS-1:0]          report_r, report_nxt;

  logic [SW-1:0]                     seek_wide, neg_wide;
  logic [SPEED_BITS-1:0]             pos_seek, neg_seek;
  logic [POSITION_BITS:0]            mid_sum, mid_adj, diff, abs_diff;
  logic [POSITION_BITS-1:0]          mid;
  logic [HWIDE-1:0]                  half_wide;
  logic [lsh_pkg::HALF_W-1:0]        half_sat;
  logic                              at_center, settle_zero, cnt_zero, finish;
  logic                              drv_off;

  // seek speed in both directions at the output width
  assign seek_wide = SW'(cfg.seek_speed);
  assign neg_wide  = SW'(0) - seek_wide;
  assign pos_seek  = seek_wide[SPEED_BITS-1:0];
  assign neg_seek  = neg_wide[SPEED_BITS-1:0];

  // midpoint of left capture and right position, truncated toward zero
  assign mid_sum = {left_cap_r[POSITION_BITS-1], left_cap_r}
                 + {position[POSITION_BITS-1], position};
  assign mid_adj = mid_sum + {{POSITION_BITS{1'b0}}, mid_sum[POSITION_BITS] & mid_sum[0]};
  assign mid     = mid_adj[POSITION_BITS:1];

  // half travel, saturated to the report width
  assign diff      = {position[POSITION_BITS-1], position}
                   - {left_cap_r[POSITION_BITS-1], left_cap_r};
  assign abs_diff  = diff[POSITION_BITS] ? ((POSITION_BITS+1)'(0) - diff) : diff;
  assign half_wide = HWIDE'(abs_diff[POSITION_BITS-1:1]);
  assign half_sat  = (half_wide > HWIDE'(lsh_pkg::HALF_MAX)) ? lsh_pkg::HALF_MAX
                                                             : half_wide[lsh_pkg::HALF_W-1:0];

  assign at_center   = $signed(position) <= $signed(center_r);
  assign settle_zero = (cfg.settle_ticks == '0);
  assign cnt_zero    = (settle_cnt_r == '0);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      lsh_pkg::PH_RUN:    if (reset_request) phase_nxt = lsh_pkg::PH_LEFT;
      lsh_pkg::PH_LEFT:   if (limit_left)    phase_nxt = lsh_pkg::PH_RIGHT;
      lsh_pkg::PH_RIGHT:  if (limit_right)   phase_nxt = lsh_pkg::PH_CENTER;
      lsh_pkg::PH_CENTER: begin
        if (at_center) phase_nxt = settle_zero ? lsh_pkg::PH_RUN : lsh_pkg::PH_SETTLE;
      end
      lsh_pkg::PH_SETTLE: if (cnt_zero)      phase_nxt = lsh_pkg::PH_RUN;
      default:            phase_nxt = lsh_pkg::PH_RUN;
    endcase
  end

  // outputs and datapath registers
  always_comb begin
    speed_out            = '0;
    drv_off              = 1'b0;
    finish               = 1'b0;
    left_cap_nxt         = left_cap_r;
    center_nxt           = center_r;
    half_pend_nxt        = half_pend_r;
    settle_cnt_nxt       = settle_cnt_r;
    enable_nxt           = enable_r;
    report_nxt           = report_r;
    half_nxt             = half_r;
    case (phase_r)
      lsh_pkg::PH_RUN: begin
        // a pressed limit drops the enable before anything else
        if (limit_left || limit_right) enable_nxt = 1'b0;
        if (reset_request) begin
          speed_out = neg_seek;
        end else if (enable_nxt) begin
          report_nxt = position;
          speed_out  = speed_command;
        end
      end
      lsh_pkg::PH_LEFT: begin
        if (limit_left) begin
          left_cap_nxt = position;
          speed_out    = pos_seek;
        end else begin
          speed_out    = neg_seek;
        end
      end
      lsh_pkg::PH_RIGHT: begin
        if (limit_right) begin
          center_nxt    = mid;
          half_pend_nxt = half_sat;
          speed_out     = neg_seek;
        end else begin
          speed_out     = pos_seek;
        end
      end
      lsh_pkg::PH_CENTER: begin
        if (at_center) begin
          if (settle_zero) begin
            finish = 1'b1;
          end else begin
            drv_off        = 1'b1;
            settle_cnt_nxt = cfg.settle_ticks - 1'b1;
          end
        end else begin
          speed_out = neg_seek;
        end
      end
      lsh_pkg::PH_SETTLE: begin
        if (!cnt_zero) begin
          drv_off        = 1'b1;
          settle_cnt_nxt = settle_cnt_r - 1'b1;
        end else begin
          finish = 1'b1;
        end
      end
      default: ;
    endcase
    // homing complete: zero the counter, publish travel, re-enable
    if (finish) begin
      enable_nxt     = 1'b1;
      report_nxt     = '0;
      half_nxt       = half_pend_nxt;
      settle_cnt_nxt = '0;
    end
  end

  assign flags.driver_disable = drv_off;
  assign flags.zero_position  = finish;
  assign flags.reset_done     = finish;
  assign flags.enabled        = enable_nxt;
  assign flags.homing_busy    = (phase_nxt != lsh_pkg::PH_RUN);
  assign reported_position    = report_nxt;
  assign half_travel          = half_nxt;

  // state update on each beat leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lsh_pkg::PH_RUN;
      left_cap_r   <= '0;
      center_r     <= '0;
      half_r       <= '0;
      half_pend_r  <= '0;
      settle_cnt_r <= '0;
      enable_r     <= 1'b0;
      report_r     <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      left_cap_r   <= left_cap_nxt;
      center_r     <= center_nxt;
      half_r       <= half_nxt;
      half_pend_r  <= half_pend_nxt;
      settle_cnt_r <= settle_cnt_nxt;
      enable_r     <= enable_nxt;
      report_r     <= report_nxt;
    end
  end

  // motor is stopped whenever the driver is held off
  `LSH_ASSERT_SAME(a_disable_stopped, flags.driver_disable, speed_out == '0)
  // completion returns to run mode with the enable set
  `LSH_ASSERT_NEXT(a_done_to_run, step && flags.reset_done, (phase_r == lsh_pkg::PH_RUN) && enable_r)
  // no beat, no state change
  `LSH_ASSERT_NEXT(a_idle_holds, !step, $stable(phase_r) && $stable(settle_cnt_r))

endmodule
`default_nettype wire

// ===== hw/rtl/limit_switch_homing_axis_controller.sv =====
// Top level of the limit switch homing axis controller.
//
//  channel  dir  handshake              carries
//  in_ch    in   valid/ready            limits, position, speed command, homing request
//  out_ch   out  valid/ready            speed, driver/homing status, position, half travel
//  cfg      in   psel/penable/pready    seek_speed (0x0), settle_ticks (0x4)
//
// One beat per clock sustained while results are taken; each beat passes the input
// register, then the sequencer step and result are computed combinationally into the
// output register; sequencer state moves as the beat leaves.
// Synchronous active-low reset: run mode, disabled, registers at their reset values.
// A stalled output holds its register; the input register takes one more beat.
`default_nettype none
`include "limit_switch_homing_axis_controller_macros.svh"
module limit_switch_homing_axis_controller #(
  parameter int POSITION_BITS = 32,
  parameter int SPEED_BITS    = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  lsh_in_if.sink                                  in_ch,
  lsh_out_if.source                               out_ch,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lsh_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [lsh_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [lsh_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready
);

  lsh_pkg::lsh_cfg_t             cfg;
  lsh_pkg::lsh_flags_t           core_flags;
  logic [SPEED_BITS-1:0]         core_speed;
  logic [POSITION_BITS-1:0]      core_report;
  logic [lsh_pkg::HALF_W-1:0]    core_half;

  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_ll_r, s1_lr_r, s1_req_r;
  logic [POSITION_BITS-1:0]      s1_pos_r;
  logic [SPEED_BITS-1:0]         s1_cmd_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [SPEED_BITS-1:0]         speed_r;
  lsh_pkg::lsh_flags_t           flags_r;
  logic [POSITION_BITS-1:0]      report_r;
  logic [lsh_pkg::HALF_W-1:0]    half_r;

  logic                          advance, step, in_take;

  lsh_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: output register frees when empty or taken
  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ll_r  <= in_ch.limit_left;
      s1_lr_r  <= in_ch.limit_right;
      s1_pos_r <= in_ch.position;
      s1_cmd_r <= in_ch.speed_command;
      s1_req_r <= in_ch.reset_request;
    end
  end

  lsh_core #(
    .POSITION_BITS (POSITION_BITS),
    .SPEED_BITS    (SPEED_BITS)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (step),
    .cfg               (cfg),
    .limit_left        (s1_ll_r),
    .limit_right       (s1_lr_r),
    .position          (s1_pos_r),
    .speed_command     (s1_cmd_r),
    .reset_request     (s1_req_r),
    .speed_out         (core_speed),
    .flags             (core_flags),
    .reported_position (core_report),
    .half_travel       (core_half)
  );

  // result register
  always_ff @(posedge clk) begin
    if (step) begin
      speed_r  <= core_speed;
      flags_r  <= core_flags;
      report_r <= core_report;
      half_r   <= core_half;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.speed_out         = speed_r;
  assign out_ch.driver_disable    = flags_r.driver_disable;
  assign out_ch.zero_position     = flags_r.zero_position;
  assign out_ch.reset_done        = flags_r.reset_done;
  assign out_ch.enabled           = flags_r.enabled;
  assign out_ch.homing_busy       = flags_r.homing_busy;
  assign out_ch.reported_position = report_r;
  assign out_ch.half_travel       = half_r;

  // input stalls only with both stages full and the output held
  `LSH_ASSERT_SAME(a_stall_full, !in_ch.ready, s1_valid_r && out_valid_r && !out_ch.ready)

endmodule
`default_nettype wire

// ===== tb/limit_switch_homing_axis_controller_test.sv =====
// Self-checking testbench for the limit switch homing axis controller.
`timescale 1ns / 100ps
module limit_switch_homing_axis_controller_test;

  localparam int POS_W = 32;
  localparam int SPD_W = 16;
  localparam int STALL_LIMIT = 500;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  typedef struct packed {
    logic             limit_left;
    logic             limit_right;
    logic [POS_W-1:0] position;
    logic [SPD_W-1:0] speed_command;
    logic             reset_request;
  } axis_tick_t;

  typedef struct packed {
    logic [SPD_W-1:0]           speed;
    lsh_pkg::lsh_flags_t        flags;
    logic [POS_W-1:0]           reported;
    logic [lsh_pkg::HALF_W-1:0] half_travel;
  } axis_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [lsh_pkg::CFG_ADDR_W-1:0] paddr;
  logic [lsh_pkg::APB_DATA_W-1:0] pwdata, prdata;

  lsh_in_if  #(.POSITION_BITS(POS_W), .SPEED_BITS(SPD_W)) in_ch ();
  lsh_out_if #(.POSITION_BITS(POS_W), .SPEED_BITS(SPD_W)) out_ch ();

  limit_switch_homing_axis_controller #(
    .POSITION_BITS(POS_W),
    .SPEED_BITS   (SPD_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  // shared run control
  bit          idle_on = 1'b1;
  int unsigned hold_cycles = 0;
  int          ticks_sent = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  axis_result_t expected_beats[$];

  // axis state as the block should hold it
  logic [lsh_pkg::SEEK_W-1:0]   seek_cfg = lsh_pkg::SEEK_RESET;
  logic [lsh_pkg::SETTLE_W-1:0] settle_cfg = lsh_pkg::SETTLE_RESET;
  lsh_pkg::lsh_phase_t          home_phase = lsh_pkg::PH_RUN;
  logic [POS_W-1:0]             left_pos = '0;
  logic [POS_W-1:0]             centre_pos = '0;
  logic [POS_W-1:0]             report_pos = '0;
  logic [lsh_pkg::HALF_W-1:0]   half_reg = '0;
  logic [lsh_pkg::HALF_W-1:0]   half_pend = '0;
  logic [lsh_pkg::SETTLE_W-1:0] settle_left = '0;
  logic                         en_flag = 1'b0;

  // one control tick of the homing sequencer; returns the beat it produces
  function automatic axis_result_t step_axis(input axis_tick_t t);
    axis_result_t r;
    logic [SPD_W-1:0] fwd, back;
    longint lft, pos, span;
    logic finish;
    r = '0;
    finish = 1'b0;
    fwd = SPD_W'(seek_cfg);
    back = -fwd;
    lft = $signed(left_pos);
    pos = $signed(t.position);
    case (home_phase)
      lsh_pkg::PH_LEFT: begin
        if (t.limit_left) begin
          left_pos = t.position;
          home_phase = lsh_pkg::PH_RIGHT;
          r.speed = fwd;
        end else begin
          r.speed = back;
        end
      end
      lsh_pkg::PH_RIGHT: begin
        r.speed = t.limit_right ? back : fwd;
        if (t.limit_right) begin
          // midpoint truncates toward zero; distance halved then saturated
          centre_pos = POS_W'((lft + pos) / 2);
          span = (pos >= lft) ? pos - lft : lft - pos;
          span = span >>> 1;
          half_pend = (span > longint'(lsh_pkg::HALF_MAX)) ? lsh_pkg::HALF_MAX
                                                           : lsh_pkg::HALF_W'(span);
          home_phase = lsh_pkg::PH_CENTER;
        end
      end
      lsh_pkg::PH_CENTER: begin
        if ($signed(t.position) <= $signed(centre_pos)) begin
          r.speed = '0;
          if (settle_cfg == '0) begin
            finish = 1'b1;
          end else begin
            r.flags.driver_disable = 1'b1;
            settle_left = settle_cfg - 1'b1;
            home_phase = lsh_pkg::PH_SETTLE;
          end
        end else begin
          r.speed = back;
        end
      end
      lsh_pkg::PH_SETTLE: begin
        if (settle_left != '0) begin
          r.flags.driver_disable = 1'b1;
          settle_left = settle_left - 1'b1;
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        if (t.limit_left || t.limit_right) en_flag = 1'b0;
        if (t.reset_request) begin
          home_phase = lsh_pkg::PH_LEFT;
          r.speed = back;
        end else if (en_flag) begin
          report_pos = t.position;
          r.speed = t.speed_command;
        end
      end
    endcase
    if (finish) begin
      r.flags.zero_position = 1'b1;
      r.flags.reset_done = 1'b1;
      en_flag = 1'b1;
      report_pos = '0;
      half_reg = half_pend;
      settle_left = '0;
      home_phase = lsh_pkg::PH_RUN;
    end
    r.flags.enabled = en_flag;
    r.flags.homing_busy = (home_phase != lsh_pkg::PH_RUN);
    r.reported = report_pos;
    r.half_travel = half_reg;
    return r;
  endfunction

  function automatic axis_tick_t tick_of(input logic ll, input logic lr,
                                         input logic [POS_W-1:0] pos,
                                         input logic [SPD_W-1:0] cmd, input logic req);
    axis_tick_t t;
    t.limit_left = ll;
    t.limit_right = lr;
    t.position = pos;
    t.speed_command = cmd;
    t.reset_request = req;
    return t;
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic axis_tick_t rand_tick();
    return tick_of($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, $urandom(),
                   SPD_W'($urandom()), $urandom_range(0, 7) == 0);
  endfunction

  // run-mode tick: no request, limits rare
  function automatic axis_tick_t run_tick();
    return tick_of($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, $urandom(),
                   SPD_W'($urandom()), 1'b0);
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return POS_W'($urandom_range(0, 40000)) - 32'd20000;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // offer one beat, with an occasional gap in front; predict on acceptance
  task automatic send_tick(input axis_tick_t t);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.limit_left <= t.limit_left;
    in_ch.limit_right <= t.limit_right;
    in_ch.position <= t.position;
    in_ch.speed_command <= t.speed_command;
    in_ch.reset_request <= t.reset_request;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_beats.push_back(step_axis(t));
    ticks_sent++;
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic cfg_write(input logic [lsh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    logic [lsh_pkg::APB_DATA_W-1:0] rd, want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == lsh_pkg::REG_SEEK) begin
      seek_cfg = value[lsh_pkg::SEEK_W-1:0];
      want = lsh_pkg::APB_DATA_W'(seek_cfg);
    end else begin
      settle_cfg = value[lsh_pkg::SETTLE_W-1:0];
      want = lsh_pkg::APB_DATA_W'(settle_cfg);
    end
    check_field("register read-back", want, rd);
    // bus left idle before the next transfer
    @(posedge clk);
  endtask

  // finish any homing left open by noise: both limits, lowest position
  task automatic drive_to_run();
    while (home_phase != lsh_pkg::PH_RUN)
      send_tick(tick_of(1'b1, 1'b1, 32'h8000_0000, SPD_W'($urandom()), coin()));
  endtask

  // a complete homing pass with random filler between the phase events
  task automatic homing_run(input logic [POS_W-1:0] left_at, input logic [POS_W-1:0] right_at);
    longint mid, p;
    drive_to_run();
    send_tick(tick_of(coin(), coin(), $urandom(), SPD_W'($urandom()), 1'b1));
    repeat ($urandom_range(0, 4))
      send_tick(tick_of(1'b0, coin(), $urandom(), SPD_W'($urandom()), coin()));
    send_tick(tick_of(1'b1, coin(), left_at, SPD_W'($urandom()), coin()));
    repeat ($urandom_range(0, 4))
      send_tick(tick_of(coin(), 1'b0, $urandom(), SPD_W'($urandom()), coin()));
    send_tick(tick_of(coin(), 1'b1, right_at, SPD_W'($urandom()), coin()));
    mid = ($signed(left_at) + $signed(right_at)) / 2;
    repeat ($urandom_range(0, 4)) begin
      p = mid + 1 + longint'($urandom_range(0, 500));
      if (p > POS_MAX) p = POS_MAX;
      send_tick(tick_of(coin(), coin(), POS_W'(p), SPD_W'($urandom()), coin()));
    end
    p = mid - longint'($urandom_range(0, 2));
    if (p < POS_MIN) p = POS_MIN;
    send_tick(tick_of(coin(), coin(), POS_W'(p), SPD_W'($urandom()), coin()));
    while (home_phase != lsh_pkg::PH_RUN) send_tick(rand_tick());
  endtask

  // after reset the axis is disabled: speed stays zero whatever is commanded
  task automatic test_reset_state();
    send_tick(tick_of(1'b0, 1'b0, 32'h7FFF_FFFF, 16'h7FFF, 1'b0));
    send_tick(tick_of(1'b1, 1'b0, 32'h8000_0000, 16'h8000, 1'b0));
    send_tick(tick_of(1'b0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
    send_tick(tick_of(1'b1, 1'b1, 32'h0000_0000, 16'h0000, 1'b0));
  endtask

  // homing at reset configuration across the full position range
  task automatic test_homing_default_config();
    homing_run(32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  // enabled run mode passes the command through until a limit is hit
  task automatic test_speed_passthrough();
    send_tick(tick_of(1'b0, 1'b0, 32'h7FFF_FFFF, 16'h7FFF, 1'b0));
    send_tick(tick_of(1'b0, 1'b0, 32'h8000_0000, 16'h8000, 1'b0));
    send_tick(tick_of(1'b0, 1'b0, 32'h0000_0001, 16'h0000, 1'b0));
    send_tick(tick_of(1'b0, 1'b1, 32'h0000_1234, 16'h4000, 1'b0));
    send_tick(tick_of(1'b0, 1'b0, 32'h0000_5678, 16'h4000, 1'b0));
  endtask

  // seek speed and settle time at their extremes, request-tick and centre corners
  task automatic test_config_extremes();
    wait_drain();
    cfg_write(lsh_pkg::REG_SEEK, 32'd0);
    cfg_write(lsh_pkg::REG_SETTLE, 32'd0);
    // request tick ignores limits for the sequencer but clears the enable flag
    send_tick(tick_of(1'b1, 1'b1, 32'd0, 16'h1111, 1'b1));
    send_tick(tick_of(1'b0, 1'b1, 32'd50, 16'h2222, 1'b1));
    send_tick(tick_of(1'b1, 1'b1, 32'd100, 16'h3333, 1'b1));
    send_tick(tick_of(1'b1, 1'b0, 32'd150, 16'h4444, 1'b1));
    send_tick(tick_of(1'b0, 1'b1, 32'd301, 16'h5555, 1'b0));
    send_tick(tick_of(1'b1, 1'b1, 32'd201, 16'h6666, 1'b1));
    // reaching the centre with no settle time completes at once
    send_tick(tick_of(1'b0, 1'b0, 32'd200, 16'h7777, 1'b0));
    send_tick(tick_of(1'b0, 1'b0, 32'd10, 16'h1234, 1'b0));
    wait_drain();
    cfg_write(lsh_pkg::REG_SEEK, 32'd32767);
    cfg_write(lsh_pkg::REG_SETTLE, 32'd1);
    // right below left, odd negative sum
    homing_run(32'd5, -32'sd8);
  endtask

  // receiver holds off long enough for the input side to back up
  task automatic test_output_stall();
    idle_on = 1'b0;
    hold_cycles = 120;
    repeat (24) send_tick(run_tick());
    wait_drain();
  endtask

  task automatic test_random_sequences();
    int first;
    first = ticks_sent;
    while (ticks_sent - first < 420) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        wait_drain();
        cfg_write(lsh_pkg::REG_SEEK, $urandom_range(0, 32767));
        cfg_write(lsh_pkg::REG_SETTLE, $urandom_range(0, 6));
      end
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 12)) send_tick(rand_tick());
        2: begin
          // homing request followed by rubbish
          send_tick(tick_of(coin(), coin(), $urandom(), SPD_W'($urandom()), 1'b1));
          repeat ($urandom_range(1, 8)) send_tick(rand_tick());
        end
        default: begin
          homing_run(pick_pos(), pick_pos());
          repeat ($urandom_range(1, 8)) send_tick(run_tick());
        end
      endcase
    end
  endtask

  // settle time well above the random range, no idling on either side
  task automatic test_long_settle();
    idle_on = 1'b0;
    wait_drain();
    cfg_write(lsh_pkg::REG_SEEK, $urandom_range(0, 32767));
    cfg_write(lsh_pkg::REG_SETTLE, 32'd60);
    homing_run(pick_pos(), pick_pos());
    repeat (4) send_tick(run_tick());
  endtask

  // receiver side: random stalls, plus a long hold-off on request
  initial begin : out_ready_driver
    int unsigned n;
    forever begin
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_checker
    axis_result_t seen, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.speed = out_ch.speed_out;
      seen.flags.driver_disable = out_ch.driver_disable;
      seen.flags.zero_position = out_ch.zero_position;
      seen.flags.reset_done = out_ch.reset_done;
      seen.flags.enabled = out_ch.enabled;
      seen.flags.homing_busy = out_ch.homing_busy;
      seen.reported = out_ch.reported_position;
      seen.half_travel = out_ch.half_travel;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none, actual speed_out %0h",
                 $time, seen.speed);
      end else begin
        want = expected_beats.pop_front();
        check_field("speed_out", want.speed, seen.speed);
        check_field("driver_disable", want.flags.driver_disable, seen.flags.driver_disable);
        check_field("zero_position", want.flags.zero_position, seen.flags.zero_position);
        check_field("reset_done", want.flags.reset_done, seen.flags.reset_done);
        check_field("enabled", want.flags.enabled, seen.flags.enabled);
        check_field("homing_busy", want.flags.homing_busy, seen.flags.homing_busy);
        check_field("reported_position", want.reported, seen.reported);
        check_field("half_travel", want.half_travel, seen.half_travel);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.limit_left <= 1'b0;
    in_ch.limit_right <= 1'b0;
    in_ch.position <= '0;
    in_ch.speed_command <= '0;
    in_ch.reset_request <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_homing_default_config();
    test_speed_passthrough();
    test_config_extremes();
    test_output_stall();
    test_random_sequences();
    test_long_settle();

    wait_drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lsh_pkg.sv
hw/rtl/lsh_in_if.sv
hw/rtl/lsh_out_if.sv
hw/rtl/lsh_cfg_regs.sv
hw/rtl/lsh_core.sv
hw/rtl/limit_switch_homing_axis_controller.sv
tb/limit_switch_homing_axis_controller_test.sv
